### hdl/hrbd_pkg.sv
// ----------------------------------------------------------------------------
// hrbd_pkg
// Shared types and constants of the http response body decoder: parse
// phases, chunk size line states, outcome codes and the result record.
// ----------------------------------------------------------------------------
package hrbd_pkg;

   // counter and chunk size widths
   localparam int COUNT_WIDTH      = 32;
   localparam int CHUNK_SIZE_WIDTH = 32;

   // widths of the result fields on the ports
   localparam int OUT_COUNT_W  = 32;
   localparam int STATUS_W     = 10;

   // header matching
   localparam int KEY_LEN  = 17;
   localparam int VAL_LEN  = 7;
   localparam int KEY_POS_W = $clog2(KEY_LEN + 1);
   localparam int VAL_POS_W = $clog2(VAL_LEN + 1);

   localparam int HEX_BASE = 16;
   localparam int CODE_MAX = 999;

   // result queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // byte codes
   localparam logic [7:0] CHR_CR    = 8'h0D;
   localparam logic [7:0] CHR_LF    = 8'h0A;
   localparam logic [7:0] CHR_SPACE = 8'h20;
   localparam logic [7:0] CHR_COLON = 8'h3A;
   localparam logic [7:0] CHR_C     = 8'h63;
   localparam logic [23:0] HDR_END_TAIL = 24'h0D0A0D;

   typedef enum logic [3:0] {
      PH_VERSION     = 4'd0,
      PH_DIGITS      = 4'd1,
      PH_STATUS_REST = 4'd2,
      PH_KEY         = 4'd3,
      PH_VAL_TE      = 4'd4,
      PH_VAL_OTHER   = 4'd5,
      PH_HDR_STOP    = 4'd6,
      PH_RAW         = 4'd7,
      PH_SIZE        = 4'd8,
      PH_DATA        = 4'd9,
      PH_SKIP        = 4'd10,
      PH_DONE        = 4'd11,
      PH_BAD_SIZE    = 4'd12,
      PH_NO_STATUS   = 4'd13
   } phase_type;

   typedef enum logic [1:0] {
      SZ_AWAIT   = 2'd0,
      SZ_DIGITS  = 2'd1,
      SZ_TRAILER = 2'd2,
      SZ_BAD     = 2'd3
   } size_state_type;

   typedef enum logic [2:0] {
      OC_OK          = 3'd0,
      OC_EMPTY       = 3'd1,
      OC_NO_HDR_END  = 3'd2,
      OC_NO_STATUS   = 3'd3,
      OC_BAD_SIZE    = 3'd4,
      OC_TRUNCATED   = 3'd5
   } outcome_type;

   typedef enum logic {
      KIND_BODY    = 1'b0,
      KIND_SUMMARY = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [7:0]              body_byte;
      logic [STATUS_W-1:0]     http_status;
      logic [OUT_COUNT_W-1:0]  body_count;
      logic                    is_chunked;
      outcome_type             outcome;
      logic [OUT_COUNT_W-1:0]  partial_count;
      logic                    run_last;
   } result_type;

endpackage

### hdl/http_response_body_decoder.sv
// ----------------------------------------------------------------------------
// http_response_body_decoder
// Streaming HTTP/1.1 response parser with chunked transfer decoding.
// ----------------------------------------------------------------------------
// Each request transaction carries one response byte. The byte is parsed in
// the cycle it is taken: the parse state updates and up to two results (a
// body byte, and on end_of_data an end-of-response summary) go into a
// four-entry result queue. The stream runs at one byte per clock while
// req_ready is high; a final byte that is also a body byte yields two
// results. req_ready follows the queue fill, which leaves room for two
// results, so it drops only while the result side is stalled. After the
// summary the decoder is back in its reset state, ready for the next
// response.
module http_response_body_decoder
   import hrbd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_end_of_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_kind,
   output logic [7:0]             rsp_body_byte,
   output logic [STATUS_W-1:0]    rsp_http_status,
   output logic [OUT_COUNT_W-1:0] rsp_body_count,
   output logic                   rsp_is_chunked,
   output logic [2:0]             rsp_outcome,
   output logic [OUT_COUNT_W-1:0] rsp_partial_count,
   output logic                   rsp_run_last
);

   phase_type                   phase_ff, phase_in;
   logic [23:0]                 tail_ff, tail_in;
   logic [STATUS_W-1:0]         code_ff, code_in;
   logic                        digit_seen_ff, digit_seen_in;
   logic [KEY_POS_W-1:0]        key_pos_ff, key_pos_in;
   logic                        key_mismatch_ff, key_mismatch_in;
   logic [VAL_POS_W-1:0]        val_pos_ff, val_pos_in;
   logic                        line_chunked_ff, line_chunked_in;
   logic                        chunked_ff, chunked_in;
   logic [CHUNK_SIZE_WIDTH-1:0] size_acc_ff, size_acc_in;
   size_state_type              size_state_ff, size_state_in;
   logic [CHUNK_SIZE_WIDTH-1:0] remaining_ff, remaining_in;
   logic [1:0]                  skip_ff, skip_in;
   logic [COUNT_WIDTH-1:0]      body_counter_ff, body_counter_in;
   logic [COUNT_WIDTH-1:0]      progress_ff, progress_in;

   logic                        accept;
   logic [7:0]                  b;
   logic                        clear_window;
   logic                        emit_body;
   logic [13:0]                 code_mul;
   logic [4:0]                  hex_digit;
   logic [CHUNK_SIZE_WIDTH-1:0] remaining_dec;
   logic [COUNT_WIDTH-1:0]      progress_inc;
   outcome_type                 oc;
   logic                        good;
   result_type                  body_res;
   result_type                  sum_res;
   result_type                  push_first;
   result_type                  push_second;
   result_type                  out_data;
   logic [1:0]                  push_count;
   logic                        room;

   function automatic logic [7:0] key_char(input logic [KEY_POS_W-1:0] idx);
      logic [7:0] c;
      case (idx)
         5'd0:    c = "T";
         5'd1:    c = "r";
         5'd2:    c = "a";
         5'd3:    c = "n";
         5'd4:    c = "s";
         5'd5:    c = "f";
         5'd6:    c = "e";
         5'd7:    c = "r";
         5'd8:    c = "-";
         5'd9:    c = "E";
         5'd10:   c = "n";
         5'd11:   c = "c";
         5'd12:   c = "o";
         5'd13:   c = "d";
         5'd14:   c = "i";
         5'd15:   c = "n";
         5'd16:   c = "g";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] val_char(input logic [VAL_POS_W-1:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = "c";
         3'd1:    c = "h";
         3'd2:    c = "u";
         3'd3:    c = "n";
         3'd4:    c = "k";
         3'd5:    c = "e";
         3'd6:    c = "d";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // bit 4 flags a hex digit, bits 3:0 hold its value
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] h;
      if (c inside {["0":"9"]}) begin
         h = {1'b1, 4'(c - "0")};
      end else if (c inside {["a":"f"]}) begin
         h = {1'b1, 4'(c - "a" + 8'd10)};
      end else if (c inside {["A":"F"]}) begin
         h = {1'b1, 4'(c - "A" + 8'd10)};
      end else begin
         h = 5'd0;
      end
      return h;
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] x,
                                                      input logic [COUNT_WIDTH-1:0] y);
      logic [COUNT_WIDTH:0] s;
      s = {1'b0, x} + {1'b0, y};
      return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
   endfunction

   assign accept    = req_valid && req_ready;
   assign req_ready = room;
   assign b         = req_data_byte;
   assign code_mul  = 14'(code_ff) * 14'd10 + 14'(b - "0");
   assign hex_digit = hex_value(b);
   assign remaining_dec = (remaining_ff != '0) ? remaining_ff - CHUNK_SIZE_WIDTH'(1)
                                               : remaining_ff;
   assign progress_inc  = sat_add(progress_ff, COUNT_WIDTH'(1));

   always_comb begin
      phase_in        = phase_ff;
      code_in         = code_ff;
      digit_seen_in   = digit_seen_ff;
      key_pos_in      = key_pos_ff;
      key_mismatch_in = key_mismatch_ff;
      val_pos_in      = val_pos_ff;
      line_chunked_in = line_chunked_ff;
      chunked_in      = chunked_ff;
      size_acc_in     = size_acc_ff;
      size_state_in   = size_state_ff;
      remaining_in    = remaining_ff;
      skip_in         = skip_ff;
      body_counter_in = body_counter_ff;
      progress_in     = progress_ff;
      clear_window    = 1'b0;
      emit_body       = 1'b0;

      if (phase_ff < PH_RAW && tail_ff == HDR_END_TAIL && b == CHR_LF) begin
         if (!digit_seen_ff) begin
            phase_in = PH_NO_STATUS;
         end else if (chunked_ff) begin
            phase_in      = PH_SIZE;
            size_acc_in   = '0;
            size_state_in = SZ_AWAIT;
            clear_window  = 1'b1;
         end else begin
            phase_in = PH_RAW;
         end
      end else begin
         case (phase_ff)
            PH_VERSION: begin
               if (b == CHR_SPACE) phase_in = PH_DIGITS;
            end
            PH_DIGITS: begin
               if (b inside {["0":"9"]}) begin
                  code_in       = (code_mul > 14'(CODE_MAX)) ? STATUS_W'(CODE_MAX)
                                                             : code_mul[STATUS_W-1:0];
                  digit_seen_in = 1'b1;
               end else if (b == CHR_LF) begin
                  key_pos_in      = '0;
                  key_mismatch_in = 1'b0;
                  phase_in        = PH_KEY;
               end else begin
                  phase_in = PH_STATUS_REST;
               end
            end
            PH_STATUS_REST: begin
               if (b == CHR_LF) begin
                  key_pos_in      = '0;
                  key_mismatch_in = 1'b0;
                  phase_in        = PH_KEY;
               end
            end
            PH_KEY: begin
               // an empty line stops header parsing
               if (key_pos_ff == '0 && !key_mismatch_ff && (b == CHR_CR || b == CHR_LF)) begin
                  phase_in = PH_HDR_STOP;
               end else if (b == CHR_COLON) begin
                  if (!key_mismatch_ff && key_pos_ff == KEY_POS_W'(KEY_LEN)) begin
                     val_pos_in      = '0;
                     line_chunked_in = 1'b0;
                     phase_in        = PH_VAL_TE;
                  end else begin
                     phase_in = PH_VAL_OTHER;
                  end
               end else if (b == CHR_LF) begin
                  key_pos_in      = '0;
                  key_mismatch_in = 1'b0;
                  phase_in        = PH_KEY;
               end else if (!key_mismatch_ff && key_pos_ff < KEY_POS_W'(KEY_LEN) &&
                            b == key_char(key_pos_ff)) begin
                  key_pos_in = key_pos_ff + KEY_POS_W'(1);
               end else begin
                  key_mismatch_in = 1'b1;
               end
            end
            PH_VAL_TE: begin
               if (b == CHR_LF) begin
                  chunked_in      = line_chunked_ff;
                  key_pos_in      = '0;
                  key_mismatch_in = 1'b0;
                  phase_in        = PH_KEY;
               end else if (val_pos_ff < VAL_POS_W'(VAL_LEN) && b == val_char(val_pos_ff)) begin
                  if (val_pos_ff == VAL_POS_W'(VAL_LEN - 1)) begin
                     line_chunked_in = 1'b1;
                     val_pos_in      = '0;
                  end else begin
                     val_pos_in = val_pos_ff + VAL_POS_W'(1);
                  end
               end else begin
                  val_pos_in = (b == CHR_C) ? VAL_POS_W'(1) : '0;
               end
            end
            PH_VAL_OTHER: begin
               if (b == CHR_LF) begin
                  key_pos_in      = '0;
                  key_mismatch_in = 1'b0;
                  phase_in        = PH_KEY;
               end
            end
            PH_RAW: begin
               emit_body       = 1'b1;
               body_counter_in = sat_add(body_counter_ff, COUNT_WIDTH'(1));
            end
            PH_SIZE: begin
               if (b == CHR_LF && tail_ff[7:0] == CHR_CR) begin
                  if (size_state_ff == SZ_AWAIT || size_state_ff == SZ_BAD) begin
                     phase_in = PH_BAD_SIZE;
                  end else if (size_acc_ff == '0) begin
                     phase_in = PH_DONE;
                  end else begin
                     remaining_in = size_acc_ff;
                     progress_in  = '0;
                     phase_in     = PH_DATA;
                  end
               end else if (hex_digit[4]) begin
                  if (size_state_ff == SZ_AWAIT || size_state_ff == SZ_DIGITS) begin
                     // one more digit would not fit the size width
                     if (size_acc_ff[CHUNK_SIZE_WIDTH-1 -: 4] != 4'd0) begin
                        size_state_in = SZ_BAD;
                     end else begin
                        size_acc_in   = {size_acc_ff[CHUNK_SIZE_WIDTH-5:0], hex_digit[3:0]};
                        size_state_in = SZ_DIGITS;
                     end
                  end
               end else if (size_state_ff == SZ_DIGITS) begin
                  size_state_in = SZ_TRAILER;
               end else if (size_state_ff == SZ_AWAIT &&
                            !(b == CHR_SPACE || (b >= 8'h09 && b <= 8'h0D))) begin
                  size_state_in = SZ_BAD;
               end
            end
            PH_DATA: begin
               emit_body    = 1'b1;
               progress_in  = progress_inc;
               remaining_in = remaining_dec;
               if (remaining_dec == '0) begin
                  body_counter_in = sat_add(body_counter_ff, progress_inc);
                  progress_in     = '0;
                  skip_in         = 2'd2;
                  phase_in        = PH_SKIP;
               end
            end
            PH_SKIP: begin
               skip_in = (skip_ff != 2'd0) ? skip_ff - 2'd1 : skip_ff;
               if (skip_in == 2'd0) begin
                  phase_in      = PH_SIZE;
                  size_acc_in   = '0;
                  size_state_in = SZ_AWAIT;
                  clear_window  = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      tail_in = clear_window ? 24'd0 : {tail_ff[15:0], b};
   end

   // summary built from the state left by this byte
   always_comb begin
      if (phase_in < PH_RAW) begin
         oc = OC_NO_HDR_END;
      end else if (phase_in == PH_NO_STATUS) begin
         oc = OC_NO_STATUS;
      end else if (phase_in == PH_BAD_SIZE) begin
         oc = OC_BAD_SIZE;
      end else if (phase_in == PH_DATA) begin
         oc = OC_TRUNCATED;
      end else begin
         oc = OC_OK;
      end
      good = (oc == OC_OK) || (oc == OC_TRUNCATED);

      body_res               = '0;
      body_res.kind          = KIND_BODY;
      body_res.body_byte     = b;
      body_res.run_last      = !req_end_of_data;

      sum_res                = '0;
      sum_res.kind           = KIND_SUMMARY;
      sum_res.http_status    = good ? code_in : '0;
      sum_res.body_count     = good ? OUT_COUNT_W'(body_counter_in) : '0;
      sum_res.is_chunked     = (phase_in >= PH_RAW) && chunked_in;
      sum_res.outcome        = oc;
      sum_res.partial_count  = (oc == OC_TRUNCATED) ? OUT_COUNT_W'(progress_in) : '0;
      sum_res.run_last       = 1'b1;

      push_first  = emit_body ? body_res : sum_res;
      push_second = sum_res;
      if (!accept) begin
         push_count = 2'd0;
      end else begin
         push_count = 2'(emit_body) + 2'(req_end_of_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_end_of_data)) begin
         phase_ff        <= PH_VERSION;
         tail_ff         <= '0;
         code_ff         <= '0;
         digit_seen_ff   <= 1'b0;
         key_pos_ff      <= '0;
         key_mismatch_ff <= 1'b0;
         val_pos_ff      <= '0;
         line_chunked_ff <= 1'b0;
         chunked_ff      <= 1'b0;
         size_acc_ff     <= '0;
         size_state_ff   <= SZ_AWAIT;
         remaining_ff    <= '0;
         skip_ff         <= '0;
         body_counter_ff <= '0;
         progress_ff     <= '0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         tail_ff         <= tail_in;
         code_ff         <= code_in;
         digit_seen_ff   <= digit_seen_in;
         key_pos_ff      <= key_pos_in;
         key_mismatch_ff <= key_mismatch_in;
         val_pos_ff      <= val_pos_in;
         line_chunked_ff <= line_chunked_in;
         chunked_ff      <= chunked_in;
         size_acc_ff     <= size_acc_in;
         size_state_ff   <= size_state_in;
         remaining_ff    <= remaining_in;
         skip_ff         <= skip_in;
         body_counter_ff <= body_counter_in;
         progress_ff     <= progress_in;
      end
   end

   hrbd_result_fifo u_result_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_count  (push_count),
      .push_first  (push_first),
      .push_second (push_second),
      .has_room    (room),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_data    (out_data)
   );

   assign rsp_kind          = out_data.kind;
   assign rsp_body_byte     = out_data.body_byte;
   assign rsp_http_status   = out_data.http_status;
   assign rsp_body_count    = out_data.body_count;
   assign rsp_is_chunked    = out_data.is_chunked;
   assign rsp_outcome       = out_data.outcome;
   assign rsp_partial_count = out_data.partial_count;
   assign rsp_run_last      = out_data.run_last;

`ifndef SYNTHESIS
   a_end_resets: assert property (@(posedge clock) disable iff (reset)
      (accept && req_end_of_data) |=> (phase_ff == PH_VERSION && body_counter_ff == '0 &&
                                       tail_ff == '0))
      else $error("state not cleared after end of response");

   a_data_remaining: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> remaining_ff != '0)
      else $error("chunk data phase with nothing remaining");

   a_skip_remaining: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SKIP |-> skip_ff != 2'd0)
      else $error("skip phase with nothing to skip");
`endif

endmodule

### hdl/hrbd_result_fifo.sv
// ----------------------------------------------------------------------------
// hrbd_result_fifo
// Small result queue: takes up to two results per cycle from the parser and
// hands them out one per transaction on the result channel.
// ----------------------------------------------------------------------------
module hrbd_result_fifo
   import hrbd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] push_count,
   input  result_type push_first,
   input  result_type push_second,
   output logic       has_room,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   result_type             entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff;
   logic [FIFO_PTR_W-1:0]  wr_ptr_in;
   logic [FIFO_PTR_W-1:0]  rd_ptr_ff;
   logic [FIFO_PTR_W-1:0]  rd_ptr_in;
   logic [FIFO_CNT_W-1:0]  count_ff;
   logic [FIFO_CNT_W-1:0]  count_in;
   logic [FIFO_PTR_W-1:0]  wr_ptr_next;
   logic                   pop;

   // room is judged on the registered count so ready does not wait on rsp_ready
   assign has_room    = count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2);
   assign out_valid   = count_ff != '0;
   assign out_data    = entry_ff[rd_ptr_ff];
   assign pop         = out_valid && out_ready;
   assign wr_ptr_next = wr_ptr_ff + FIFO_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push_count);
      rd_ptr_in = pop ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + FIFO_CNT_W'(push_count) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_first;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push_second;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("result queue count beyond depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push_count != 2'd0 |-> count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2))
      else $error("results pushed without room");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (pop && push_count == 2'd0) |=> count_ff == $past(count_ff) - FIFO_CNT_W'(1))
      else $error("pop did not lower the count");
`endif

endmodule

### test/http_response_body_decoder_tb.sv
// ----------------------------------------------------------------------------
// http_response_body_decoder_tb
// Self-checking bench for the HTTP/1.1 response body decoder. A short table
// of canned responses runs first, most with their summaries typed in, then
// generated responses (mostly well formed, raw and chunked, some cut short or
// broken, some plain noise) under three sender/receiver idle mixes. A
// behavioral decoder predicts every body byte and every summary not typed
// in, and a scoreboard compares each result transaction field by field.
// ----------------------------------------------------------------------------
module http_response_body_decoder_tb;
   import hrbd_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEMS_PER_MIX = 340;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_data_byte = 8'h00;
   logic                   req_end_of_data = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_kind;
   logic [7:0]             rsp_body_byte;
   logic [STATUS_W-1:0]    rsp_http_status;
   logic [OUT_COUNT_W-1:0] rsp_body_count;
   logic                   rsp_is_chunked;
   logic [2:0]             rsp_outcome;
   logic [OUT_COUNT_W-1:0] rsp_partial_count;
   logic                   rsp_run_last;

   // typed-in summary travels with the byte that ends a canned response
   logic       req_typed = 1'b0;
   result_type req_typed_sum = '0;

   http_response_body_decoder i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_end_of_data   (req_end_of_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_body_byte     (rsp_body_byte),
      .rsp_http_status   (rsp_http_status),
      .rsp_body_count    (rsp_body_count),
      .rsp_is_chunked    (rsp_is_chunked),
      .rsp_outcome       (rsp_outcome),
      .rsp_partial_count (rsp_partial_count),
      .rsp_run_last      (rsp_run_last)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // behavioral decoder
   // ---------------------------------------------------------------------
   string te_key = "Transfer-Encoding";
   string te_val = "chunked";

   phase_type                   hdr_phase;
   logic [23:0]                 tail;
   int                          code;
   logic                        digit_seen;
   int                          key_pos;
   logic                        key_bad;
   int                          val_pos;
   logic                        line_chunked;
   logic                        chunked;
   logic [CHUNK_SIZE_WIDTH-1:0] size_acc;
   size_state_type              size_st;
   logic [CHUNK_SIZE_WIDTH-1:0] chunk_left;
   int                          skip_left;
   logic [COUNT_WIDTH-1:0]      body_cnt;
   logic [COUNT_WIDTH-1:0]      chunk_prog;

   result_type pending_results[$];

   function automatic void queue_result(input result_type r);
      pending_results.insert(pending_results.size(), r);
   endfunction

   function automatic void reset_decoder();
      hdr_phase    = PH_VERSION;
      tail         = '0;
      code         = 0;
      digit_seen   = 1'b0;
      key_pos      = 0;
      key_bad      = 1'b0;
      val_pos      = 0;
      line_chunked = 1'b0;
      chunked      = 1'b0;
      size_acc     = '0;
      size_st      = SZ_AWAIT;
      chunk_left   = '0;
      skip_left    = 0;
      body_cnt     = '0;
      chunk_prog   = '0;
   endfunction

   function automatic void begin_header_line();
      key_pos   = 0;
      key_bad   = 1'b0;
      hdr_phase = PH_KEY;
   endfunction

   function automatic void begin_size_line();
      size_acc = '0;
      size_st  = SZ_AWAIT;
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] sat_count(logic [COUNT_WIDTH-1:0] a,
                                                        logic [COUNT_WIDTH-1:0] b);
      logic [COUNT_WIDTH:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
   endfunction

   function automatic int hex_digit(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
   endfunction

   task automatic decode_byte(input logic [7:0] b, input logic eod, input logic typed,
                              input result_type typed_sum);
      logic [23:0] prev;
      logic        clear;
      int          h;
      logic        good;
      outcome_type oc;
      result_type  r;
      prev  = tail;
      clear = 1'b0;
      r     = '0;
      if (hdr_phase < PH_RAW && prev == HDR_END_TAIL && b == CHR_LF) begin
         if (!digit_seen) begin
            hdr_phase = PH_NO_STATUS;
         end else if (chunked) begin
            hdr_phase = PH_SIZE;
            begin_size_line();
            clear = 1'b1;
         end else begin
            hdr_phase = PH_RAW;
         end
      end else begin
         case (hdr_phase)
            PH_VERSION: begin
               if (b == CHR_SPACE) hdr_phase = PH_DIGITS;
            end
            PH_DIGITS: begin
               if (b >= "0" && b <= "9") begin
                  code = code * 10 + int'(b - "0");
                  if (code > CODE_MAX) code = CODE_MAX;
                  digit_seen = 1'b1;
               end else if (b == CHR_LF) begin
                  begin_header_line();
               end else begin
                  hdr_phase = PH_STATUS_REST;
               end
            end
            PH_STATUS_REST, PH_VAL_OTHER: begin
               if (b == CHR_LF) begin_header_line();
            end
            PH_KEY: begin
               if (key_pos == 0 && !key_bad && (b == CHR_CR || b == CHR_LF)) begin
                  hdr_phase = PH_HDR_STOP;
               end else if (b == CHR_COLON) begin
                  if (!key_bad && key_pos == KEY_LEN) begin
                     val_pos      = 0;
                     line_chunked = 1'b0;
                     hdr_phase    = PH_VAL_TE;
                  end else begin
                     hdr_phase = PH_VAL_OTHER;
                  end
               end else if (b == CHR_LF) begin
                  begin_header_line();
               end else if (!key_bad && key_pos < KEY_LEN && b == te_key[key_pos]) begin
                  key_pos++;
               end else begin
                  key_bad = 1'b1;
               end
            end
            PH_VAL_TE: begin
               if (b == CHR_LF) begin
                  chunked = line_chunked;
                  begin_header_line();
               end else if (val_pos < VAL_LEN && b == te_val[val_pos]) begin
                  val_pos++;
                  if (val_pos == VAL_LEN) begin
                     line_chunked = 1'b1;
                     val_pos      = 0;
                  end
               end else begin
                  val_pos = (b == CHR_C) ? 1 : 0;
               end
            end
            PH_RAW: begin
               r.kind      = KIND_BODY;
               r.body_byte = b;
               r.run_last  = !eod;
               queue_result(r);
               body_cnt = sat_count(body_cnt, COUNT_WIDTH'(1));
            end
            PH_SIZE: begin
               if (b == CHR_LF && prev[7:0] == CHR_CR) begin
                  if (size_st == SZ_AWAIT || size_st == SZ_BAD) begin
                     hdr_phase = PH_BAD_SIZE;
                  end else if (size_acc == 0) begin
                     hdr_phase = PH_DONE;
                  end else begin
                     chunk_left = size_acc;
                     chunk_prog = '0;
                     hdr_phase  = PH_DATA;
                  end
               end else begin
                  h = hex_digit(b);
                  if (h >= 0) begin
                     if (size_st == SZ_AWAIT || size_st == SZ_DIGITS) begin
                        // another digit would push the size past its width
                        if (size_acc[CHUNK_SIZE_WIDTH-1 -: 4] != 0) begin
                           size_st = SZ_BAD;
                        end else begin
                           size_acc = {size_acc[CHUNK_SIZE_WIDTH-5:0], 4'(h)};
                           size_st  = SZ_DIGITS;
                        end
                     end
                  end else if (size_st == SZ_DIGITS) begin
                     size_st = SZ_TRAILER;
                  end else if (size_st == SZ_AWAIT &&
                               !(b == CHR_SPACE || (b >= 8'h09 && b <= 8'h0D))) begin
                     size_st = SZ_BAD;
                  end
               end
            end
            PH_DATA: begin
               r.kind      = KIND_BODY;
               r.body_byte = b;
               r.run_last  = !eod;
               queue_result(r);
               chunk_prog = sat_count(chunk_prog, COUNT_WIDTH'(1));
               if (chunk_left > 0) chunk_left--;
               if (chunk_left == 0) begin
                  body_cnt   = sat_count(body_cnt, chunk_prog);
                  chunk_prog = '0;
                  skip_left  = 2;
                  hdr_phase  = PH_SKIP;
               end
            end
            PH_SKIP: begin
               if (skip_left > 0) skip_left--;
               if (skip_left == 0) begin
                  hdr_phase = PH_SIZE;
                  begin_size_line();
                  clear = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      tail = clear ? 24'h0 : {prev[15:0], b};

      if (eod) begin
         if (hdr_phase < PH_RAW) oc = OC_NO_HDR_END;
         else if (hdr_phase == PH_NO_STATUS) oc = OC_NO_STATUS;
         else if (hdr_phase == PH_BAD_SIZE) oc = OC_BAD_SIZE;
         else if (hdr_phase == PH_DATA) oc = OC_TRUNCATED;
         else oc = OC_OK;
         good            = (oc == OC_OK || oc == OC_TRUNCATED);
         r               = '0;
         r.kind          = KIND_SUMMARY;
         r.http_status   = good ? STATUS_W'(code) : '0;
         r.body_count    = good ? body_cnt : '0;
         r.is_chunked    = (hdr_phase >= PH_RAW) && chunked;
         r.outcome       = oc;
         r.partial_count = (oc == OC_TRUNCATED) ? chunk_prog : '0;
         r.run_last      = 1'b1;
         queue_result(typed ? typed_sum : r);
         reset_decoder();
      end
   endtask

   // ---------------------------------------------------------------------
   // scoreboard
   // ---------------------------------------------------------------------
   int errors = 0;
   int results_checked = 0;
   int outcome_tally[6] = '{default: 0};
   int cycle_count = 0;

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            decode_byte(req_data_byte, req_end_of_data, req_typed, req_typed_sum);
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("result transaction with nothing expected, kind %0d byte %0h",
                      rsp_kind, rsp_body_byte);
               errors++;
            end else begin
               want = pending_results.pop_front();
               check_field("kind", want.kind, rsp_kind);
               check_field("body_byte", want.body_byte, rsp_body_byte);
               check_field("http_status", want.http_status, rsp_http_status);
               check_field("body_count", want.body_count, rsp_body_count);
               check_field("is_chunked", want.is_chunked, rsp_is_chunked);
               check_field("outcome", want.outcome, rsp_outcome);
               check_field("partial_count", want.partial_count, rsp_partial_count);
               check_field("run_last", want.run_last, rsp_run_last);
               results_checked++;
               if (want.kind == KIND_SUMMARY) outcome_tally[want.outcome]++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // receiver: random stalls plus an occasional long hold-off
   // ---------------------------------------------------------------------
   int recv_idle_pct = 0;
   int send_idle_pct = 0;
   int stall_request = 0;

   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_request != 0) begin
            stall_left    = stall_request;
            stall_request = 0;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------------
   // sender
   // ---------------------------------------------------------------------
   logic [7:0] wire_bytes[$];
   int         bytes_sent = 0;
   int         responses_sent = 0;

   function automatic void add_byte(input logic [7:0] d);
      wire_bytes.insert(wire_bytes.size(), d);
   endfunction

   task automatic send_byte(input logic [7:0] d, input logic eod, input logic typed,
                            input result_type ts);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid       <= 1'b1;
      req_data_byte   <= d;
      req_end_of_data <= eod;
      req_typed       <= typed;
      req_typed_sum   <= ts;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_message(input logic typed, input result_type ts);
      int i;
      for (i = 0; i < wire_bytes.size(); i++)
         send_byte(wire_bytes[i], i == wire_bytes.size() - 1, typed, ts);
      responses_sent++;
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic add_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   task automatic add_random_bytes(input int n);
      repeat (n) add_byte(8'($urandom_range(255)));
   endtask

   task automatic add_header_line();
      case ($urandom_range(8))
         0: add_text("Content-Type: text/html\r\n");
         1: add_text("Content-Length: 12\r\n");
         2: add_text("transfer-encoding: chunked\r\n");
         3: add_text("Transfer-Encoding: gzip\r\n");
         4: add_text("Transfer-Encoding: gzip, chunked\r\n");
         5: add_text("X-Transfer-Encoding: chunked\r\n");
         6: add_text("Transfer-Encoding: cchunked\r\n");
         7: add_text("Transfer-Encoding:chunked\n");
         default: begin
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(33, 126)));
            add_text(": v\r\n");
         end
      endcase
   endtask

   task automatic build_response();
      int    n;
      int    len;
      int    chunk_at;
      logic  use_chunked;
      string s;
      wire_bytes.delete();
      if ($urandom_range(99) < 10) begin
         // line noise
         repeat ($urandom_range(1, 10)) begin
            case ($urandom_range(3))
               0: add_byte(CHR_CR);
               1: add_byte(CHR_LF);
               default: add_byte(8'($urandom_range(255)));
            endcase
         end
         return;
      end
      add_text("HTTP/1.1 ");
      case ($urandom_range(9))
         0: ;
         1: add_text($sformatf("%0d", $urandom_range(1000, 99999)));
         default: add_text($sformatf("%0d", $urandom_range(100, 599)));
      endcase
      if ($urandom_range(1)) add_text(" OK");
      add_text("\r\n");
      use_chunked = ($urandom_range(99) < 60);
      n           = $urandom_range(0, 3);
      chunk_at    = $urandom_range(0, n);
      for (int i = 0; i <= n; i++) begin
         if (use_chunked && i == chunk_at) add_text("Transfer-Encoding: chunked\r\n");
         if (i < n) add_header_line();
      end
      add_text("\r\n");
      if (use_chunked) begin
         repeat ($urandom_range(0, 3)) begin
            len = $urandom_range(1, 12);
            if ($urandom_range(3) == 0) add_text(" ");
            s = $sformatf("%0h", len);
            if ($urandom_range(1)) s = s.toupper();
            if ($urandom_range(3) == 0) s = {"00", s};
            add_text(s);
            if ($urandom_range(3) == 0) add_text(";ext=1");
            add_text("\r\n");
            add_random_bytes(len);
            if ($urandom_range(4) == 0) add_random_bytes(2);
            else add_text("\r\n");
         end
         case ($urandom_range(9))
            0: add_text("-4\r\n");
            1: add_text("zz\r\n");
            2: add_text("\r\n");
            3: add_text("1FFFFFFFF\r\n");
            4: add_text("0x1f\r\n");
            5: begin
               // largest size, then the data stops early
               add_text("FFFFFFFF\r\n");
               add_random_bytes(3);
            end
            default: add_text("0\r\n\r\n");
         endcase
      end else begin
         add_random_bytes($urandom_range(0, 24));
      end
      if ($urandom_range(3) == 0) begin
         len = $urandom_range(1, wire_bytes.size());
         while (wire_bytes.size() > len) void'(wire_bytes.pop_back());
      end
   endtask

   task automatic run_random(input int goal);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < goal) begin
         build_response();
         send_message(1'b0, '0);
      end
   endtask

   // canned responses; rows with typed set carry their summary
   string      canned_text[$];
   logic       canned_typed[$];
   result_type canned_want[$];

   task automatic add_canned(input string text, input logic typed, input outcome_type oc,
                             input int status, input int count, input logic chnk,
                             input int partial);
      result_type r;
      r               = '0;
      r.kind          = KIND_SUMMARY;
      r.http_status   = STATUS_W'(status);
      r.body_count    = OUT_COUNT_W'(count);
      r.is_chunked    = chnk;
      r.outcome       = oc;
      r.partial_count = OUT_COUNT_W'(partial);
      r.run_last      = 1'b1;
      canned_text.insert(canned_text.size(), text);
      canned_typed.insert(canned_typed.size(), typed);
      canned_want.insert(canned_want.size(), r);
   endtask

   initial begin
      int i;
      reset_decoder();
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 9;
      recv_idle_pct = 58;

      add_canned("x", 1, OC_NO_HDR_END, 0, 0, 0, 0);
      add_canned("\r\n\r\n", 1, OC_NO_STATUS, 0, 0, 0, 0);
      add_canned("H 9999\r\n\r\n\377", 1, OC_OK, 999, 1, 0, 0);
      add_canned("HTTP/1.1 abc\r\nX: y\r\n\r\nz", 1, OC_NO_STATUS, 0, 0, 0, 0);
      add_canned("HTTP/1.1 204\n\nxyz", 1, OC_NO_HDR_END, 0, 0, 0, 0);
      add_canned(" 200 OK\r\nTransfer-Encoding: chunked\r\n\r\n3\r\nabc\r\n0\r\n\r\n",
                 1, OC_OK, 200, 3, 1, 0);
      add_canned(" 200\r\nTransfer-Encoding: chunked\r\n\r\n5\r\nab",
                 1, OC_TRUNCATED, 200, 0, 1, 2);
      add_canned(" 200\r\nTransfer-Encoding: chunked\r\n\r\n-1\r\n",
                 1, OC_BAD_SIZE, 0, 0, 1, 0);
      // hex prefix reads as zero size
      add_canned(" 200\r\nTransfer-Encoding: chunked\r\n\r\n 0x10\r\nzz",
                 0, OC_OK, 0, 0, 0, 0);
      // last transfer-encoding line wins
      add_canned(" 200\r\nTransfer-Encoding: chunked\r\nTransfer-Encoding: gzip\r\n\r\nab",
                 0, OC_OK, 0, 0, 0, 0);
      add_canned(" 200\r\nTransfer-Encoding: chunked\r\n\r\n2\r\nhi\r\n123456789\r\n",
                 0, OC_OK, 0, 0, 0, 0);
      // two bytes after chunk data skipped whatever they are
      add_canned(" 200\r\nTransfer-Encoding: chunked\r\n\r\n1\r\nqXY0\r\n\r\n",
                 0, OC_OK, 0, 0, 0, 0);
      // unterminated size line at end of data
      add_canned(" 301\r\nTransfer-Encoding: x chunked\r\n\r\n1;a=b\r\nq\r\n7f",
                 0, OC_OK, 0, 0, 0, 0);

      for (i = 0; i < canned_text.size(); i++) begin
         wire_bytes.delete();
         add_text(canned_text[i]);
         send_message(canned_typed[i], canned_want[i]);
      end

      run_random(ITEMS_PER_MIX);
      wait_for_drain();

      send_idle_pct = 58;
      recv_idle_pct = 9;
      run_random(ITEMS_PER_MIX);
      wait_for_drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      // long body against a stalled receiver so the result queue backs up
      stall_request = 200;
      wire_bytes.delete();
      add_text("HTTP/1.1 200 OK\r\n\r\n");
      add_random_bytes(60);
      send_message(1'b0, '0);
      run_random(ITEMS_PER_MIX);
      wait_for_drain();
      repeat (16) @(negedge clock);

      $display("%0d responses, %0d bytes sent, %0d result transactions checked",
               responses_sent, bytes_sent, results_checked);
      $display("summaries: ok %0d, no header end %0d, no status %0d, bad size %0d, truncated %0d",
               outcome_tally[OC_OK], outcome_tally[OC_NO_HDR_END], outcome_tally[OC_NO_STATUS],
               outcome_tally[OC_BAD_SIZE], outcome_tally[OC_TRUNCATED]);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
